>>> rtl/core/rpsw_pkg.sv
// ----------------------------------------------------------------------------
// rpsw_pkg
// Shared widths, defaults and the stripe descriptor for the stripe writer.
// ----------------------------------------------------------------------------
package rpsw_pkg;

	localparam int BYTE_W    = 8;
	localparam int DISK_W    = 3;
	localparam int DISKS_DEF = 5;

	typedef struct packed {
		logic [DISK_W-1:0] count;
		logic [DISK_W-1:0] pdisk;
		logic [BYTE_W-1:0] parity;
	} stripe_info_t;

endpackage

>>> rtl/core/rpsw_front.sv
// ----------------------------------------------------------------------------
// rpsw_front
// Gathers input words into a stripe, folds them into parity and hands each
// closed stripe, with its parity disk, to the stripe queue.
// ----------------------------------------------------------------------------
module rpsw_front #(
	parameter int DISKS = rpsw_pkg::DISKS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [rpsw_pkg::BYTE_W-1:0]         data_byte,
	input  logic                                end_of_stream,
	input  logic                                q_full,
	output logic                                push,
	output rpsw_pkg::stripe_info_t              push_info,
	output logic [DISKS-2:0][rpsw_pkg::BYTE_W-1:0] push_data
);
	import rpsw_pkg::*;

	localparam int ND = DISKS - 1;
	localparam int KW = $clog2(ND);

	logic [DISK_W-1:0]             fill_q;
	logic [BYTE_W-1:0]             par_q;
	logic [DISK_W-1:0]             pdisk_q;
	logic [ND-1:0][BYTE_W-1:0]     buf_q;
	logic                          accept;
	logic                          close;
	logic [DISK_W-1:0]             fill_next;
	logic [BYTE_W-1:0]             par_next;

	assign in_ready  = !q_full;
	assign accept    = in_valid && in_ready;
	assign fill_next = fill_q + DISK_W'(1);
	assign par_next  = par_q ^ data_byte;
	assign close     = end_of_stream || (fill_next == DISK_W'(ND));

	always_comb begin
		push_data = buf_q;
		push_data[fill_q[KW-1:0]] = data_byte;
	end

	assign push             = accept && close;
	assign push_info.count  = fill_next;
	assign push_info.pdisk  = pdisk_q;
	assign push_info.parity = par_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			par_q   <= '0;
			pdisk_q <= '0;
		end else if (accept) begin
			if (close) begin
				fill_q <= '0;
				par_q  <= '0;
				if (end_of_stream || pdisk_q == DISK_W'(DISKS - 1))
					pdisk_q <= '0;
				else
					pdisk_q <= pdisk_q + DISK_W'(1);
			end else begin
				fill_q <= fill_next;
				par_q  <= par_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			buf_q <= push_data;
	end

endmodule

>>> rtl/core/rpsw_queue.sv
// ----------------------------------------------------------------------------
// rpsw_queue
// Two-entry queue of closed stripes between the front and back parts.
// ----------------------------------------------------------------------------
module rpsw_queue #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_word,
	input  logic         pop,
	output logic         full,
	output logic         not_empty,
	output logic [W-1:0] head
);
	logic [1:0][W-1:0] ent_q;
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [1:0]        cnt_q;

	assign full      = (cnt_q == 2'd2);
	assign not_empty = (cnt_q != 2'd0);
	assign head      = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			if (push && !pop)
				cnt_q <= cnt_q + 2'd1;
			else if (pop && !push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			ent_q[wr_ptr_q] <= push_word;
	end

endmodule

>>> rtl/core/rpsw_back.sv
// ----------------------------------------------------------------------------
// rpsw_back
// Walks each queued stripe in ascending disk order and issues one output
// word per used disk through a registered output stage.
// ----------------------------------------------------------------------------
module rpsw_back #(
	parameter int DISKS = rpsw_pkg::DISKS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   q_valid,
	input  rpsw_pkg::stripe_info_t                 q_info,
	input  logic [DISKS-2:0][rpsw_pkg::BYTE_W-1:0] q_data,
	output logic                                   q_pop,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [rpsw_pkg::DISK_W-1:0]            disk_number,
	output logic [rpsw_pkg::BYTE_W-1:0]            out_byte,
	output logic                                   is_parity,
	output logic                                   last_of_stripe
);
	import rpsw_pkg::*;

	localparam int ND = DISKS - 1;
	localparam int KW = $clog2(ND);

	logic                      active_q;
	logic [DISK_W-1:0]         d_q;
	stripe_info_t              cur_info_q;
	logic [ND-1:0][BYTE_W-1:0] cur_data_q;
	logic                      out_valid_q;
	logic [DISK_W-1:0]         disk_q;
	logic [BYTE_W-1:0]         byte_q;
	logic                      par_q;
	logic                      last_q;

	logic                      adv;
	logic [DISK_W-1:0]         last_disk;
	logic                      emit_last;
	logic                      on_parity;
	logic [DISK_W-1:0]         k;
	logic [DISK_W-1:0]         d_inc;
	logic [DISK_W-1:0]         d_next;
	logic [BYTE_W-1:0]         sel_byte;

	assign adv       = !out_valid_q || out_ready;
	assign last_disk = (cur_info_q.count > cur_info_q.pdisk) ? cur_info_q.count
	                                                         : cur_info_q.pdisk;
	assign emit_last = (d_q == last_disk);
	assign on_parity = (d_q == cur_info_q.pdisk);
	assign k         = (d_q < cur_info_q.pdisk) ? d_q : d_q - DISK_W'(1);
	assign d_inc     = d_q + DISK_W'(1);
	// skip the disks of missing data words up to the parity disk
	assign d_next    = (d_inc >= cur_info_q.count && d_inc < cur_info_q.pdisk)
	                   ? cur_info_q.pdisk : d_inc;
	assign sel_byte  = on_parity ? cur_info_q.parity : cur_data_q[k[KW-1:0]];
	assign q_pop     = adv && q_valid && (!active_q || emit_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			d_q         <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= active_q;
			if (q_pop) begin
				active_q <= 1'b1;
				d_q      <= '0;
			end else if (active_q && emit_last) begin
				active_q <= 1'b0;
			end else if (active_q) begin
				d_q <= d_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_info_q <= q_info;
			cur_data_q <= q_data;
		end
		if (adv && active_q) begin
			disk_q <= d_q;
			byte_q <= sel_byte;
			par_q  <= on_parity;
			last_q <= emit_last;
		end
	end

	assign out_valid      = out_valid_q;
	assign disk_number    = disk_q;
	assign out_byte       = byte_q;
	assign is_parity      = par_q;
	assign last_of_stripe = last_q;

endmodule

>>> rtl/core/rotating_parity_stripe_writer.sv
// ----------------------------------------------------------------------------
// rotating_parity_stripe_writer
// Stripes a byte stream over DISKS disks with rotating XOR parity.
// ----------------------------------------------------------------------------
// The front part takes one input word per cycle while the two-entry stripe
// queue has room; a stripe closes after DISKS-1 words or on end_of_stream.
// The back part issues one output word per cycle while out_ready is high,
// so DISKS-1 input words give DISKS output words and the single output
// channel sets the sustained rate. The first output word of a stripe passes
// the stripe queue and the back part's stripe and output registers once
// its closing input word is taken. The parity disk starts at 0, advances
// modulo DISKS per stripe and returns to 0 after a stream's last stripe.
// ----------------------------------------------------------------------------
module rotating_parity_stripe_writer #(
	parameter int DISKS = rpsw_pkg::DISKS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [rpsw_pkg::BYTE_W-1:0] data_byte,
	input  logic                        end_of_stream,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [rpsw_pkg::DISK_W-1:0] disk_number,
	output logic [rpsw_pkg::BYTE_W-1:0] out_byte,
	output logic                        is_parity,
	output logic                        last_of_stripe
);
	import rpsw_pkg::*;

	localparam int ND = DISKS - 1;
	localparam int QW = $bits(stripe_info_t) + ND * BYTE_W;

	logic                      push;
	stripe_info_t              push_info;
	logic [ND-1:0][BYTE_W-1:0] push_data;
	logic                      q_full;
	logic                      q_valid;
	logic                      q_pop;
	logic [QW-1:0]             q_head;
	stripe_info_t              head_info;
	logic [ND-1:0][BYTE_W-1:0] head_data;

	assign head_info = q_head[QW-1 -: $bits(stripe_info_t)];
	assign head_data = q_head[ND*BYTE_W-1:0];

	rpsw_front #(.DISKS(DISKS)) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.data_byte     (data_byte),
		.end_of_stream (end_of_stream),
		.q_full        (q_full),
		.push          (push),
		.push_info     (push_info),
		.push_data     (push_data)
	);

	rpsw_queue #(.W(QW)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_word ({push_info, push_data}),
		.pop       (q_pop),
		.full      (q_full),
		.not_empty (q_valid),
		.head      (q_head)
	);

	rpsw_back #(.DISKS(DISKS)) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_valid        (q_valid),
		.q_info         (head_info),
		.q_data         (head_data),
		.q_pop          (q_pop),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.disk_number    (disk_number),
		.out_byte       (out_byte),
		.is_parity      (is_parity),
		.last_of_stripe (last_of_stripe)
	);

endmodule
